### rtl/core/bucket_fill_map_rank_select_assert.svh
// Assertion macros used by the fill map datapath.
`ifndef BUCKET_FILL_MAP_RANK_SELECT_ASSERT_SVH
`define BUCKET_FILL_MAP_RANK_SELECT_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define BFM_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define BFM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/bfmrs_pkg.sv
// Shared constants, types and helper functions of the bucket fill map.
package bfmrs_pkg;

  // Map geometry
  localparam int BUCKET_CNT = 5120;
  localparam int WORD_W     = 64;
  localparam int WORD_CNT   = BUCKET_CNT / WORD_W;
  localparam int IDX_W      = 13;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int WADDR_W    = $clog2(WORD_CNT);
  localparam int CNT_W      = 13;
  localparam int PC_W       = BIT_W + 1;

  localparam logic [CNT_W-1:0]   DEF_TOTAL = CNT_W'(BUCKET_CNT / 2);
  localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(BUCKET_CNT);
  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORD_CNT - 1);

  // Operation codes carried in in_tuser
  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_QUERY = 2'd1,
    OP_COUNT = 2'd2,
    OP_PICK  = 2'd3
  } op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic clr_wr;
    logic upd;
    logic scan;
    logic byte_step;
    logic bit_step;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    op_t  op;
    logic loaded;
    logic rank_err;
    logic clr_last;
    logic scan_hit;
    logic byte_hit;
    logic bit_hit;
    logic out_busy;
  } sts_t;

  // Index mod 5120: 5120 = 5 * 1024, so only the top six bits need a mod 5,
  // done with a reciprocal multiply (13/64) and one correction step.
  function automatic logic [IDX_W-1:0] reduce_index(input logic [15:0] v);
    logic [5:0] hi;
    logic [9:0] prod;
    logic [3:0] quot;
    logic [5:0] q5;
    logic [5:0] r;
    hi   = v[15:10];
    prod = {4'd0, hi} * 10'd13;
    quot = prod[9:6];
    q5   = {2'd0, quot} * 6'd5;
    r    = hi - q5;
    if (r >= 6'd5) begin
      r = r - 6'd5;
    end
    return {r[2:0], v[9:0]};
  endfunction

  // Population count of one map word
  function automatic logic [PC_W-1:0] popcnt_word(input logic [WORD_W-1:0] w);
    logic [PC_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) begin
      n = n + PC_W'(w[i]);
    end
    return n;
  endfunction

  // Population count of one byte
  function automatic logic [3:0] popcnt_byte(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(b[i]);
    end
    return n;
  endfunction

endpackage

### rtl/core/bfmrs_ctrl.sv
// Sequencer of the bucket fill map: one request at a time.
module bfmrs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  bfmrs_pkg::sts_t sts,
  output bfmrs_pkg::cmd_t cmd
);
  import bfmrs_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DISP  = 9'b000000010,
    S_CLEAR = 9'b000000100,
    S_RD    = 9'b000001000,
    S_UPD   = 9'b000010000,
    S_SCAN  = 9'b000100000,
    S_BYTE  = 9'b001000000,
    S_BIT   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op)
          OP_SET: begin
            state_nxt = sts.loaded ? S_RD : S_CLEAR;
          end
          OP_QUERY: begin
            state_nxt = sts.loaded ? S_RD : S_DONE;
          end
          OP_PICK: begin
            state_nxt = (sts.rank_err || !sts.loaded) ? S_DONE : S_SCAN;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        // word read in flight
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_hit) begin
          state_nxt = S_BYTE;
        end
      end
      S_BYTE: begin
        cmd.byte_step = 1'b1;
        if (sts.byte_hit) begin
          state_nxt = S_BIT;
        end
      end
      S_BIT: begin
        cmd.bit_step = 1'b1;
        if (sts.bit_hit) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/bfmrs_dpath.sv
// Datapath of the bucket fill map: map memory, counters, rank select, result register.
`include "bucket_fill_map_rank_select_assert.svh"

module bfmrs_dpath (
  input  logic            clk,
  input  logic            rst_n,
  input  bfmrs_pkg::cmd_t cmd,
  output bfmrs_pkg::sts_t sts,
  input  logic [31:0]     in_tdata,   // bucket_index[15:0], rank[28:16], zero fill
  input  logic [1:0]      in_tuser,   // op[1:0]
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [31:0]     out_tdata,  // is_filled[0], filled_total[13:1], picked_bucket[26:14]
  output logic [0:0]      out_tuser   // rank_error[0]
);
  import bfmrs_pkg::*;

  // Fill map memory, one word per 64 buckets
  logic [WORD_W-1:0]  mem [WORD_CNT];
  logic [WORD_W-1:0]  rd_data_r;
  logic               mem_we;
  logic [WADDR_W-1:0] mem_waddr;
  logic [WADDR_W-1:0] mem_raddr;
  logic [WORD_W-1:0]  mem_wdata;

  // Request and map state
  op_t                op_r;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   rank_r;
  logic               loaded_r;
  logic [CNT_W-1:0]   count_r;
  logic               qbit_r;

  // Sweep and select state
  logic [WADDR_W-1:0] ptr_r;
  logic               dv_r;
  logic [WADDR_W-1:0] wsel_r;
  logic [CNT_W-1:0]   seen_r;
  logic [WORD_W-1:0]  sh_r;
  logic [BIT_W-1:0]   rem_r;
  logic [IDX_W-1:0]   pos_r;

  // Result register
  logic               out_valid_r;
  logic               filled_r;
  logic [CNT_W-1:0]   total_r;
  logic [IDX_W-1:0]   picked_r;
  logic               err_r;

  logic [CNT_W-1:0]   total_w;
  logic [WADDR_W-1:0] word_w;
  logic [BIT_W-1:0]   bit_w;
  logic               cur_bit;
  logic [PC_W-1:0]    pc_w;
  logic [CNT_W:0]     sum_w;
  logic               scan_hit;
  logic [3:0]         pc8_w;
  logic               byte_hit;
  logic               bit_hit;
  logic               rank_err;
  logic               set_new;

  assign total_w  = loaded_r ? count_r : DEF_TOTAL;
  assign word_w   = idx_r[IDX_W-1:BIT_W];
  assign bit_w    = idx_r[BIT_W-1:0];
  assign cur_bit  = rd_data_r[bit_w];
  assign rank_err = (op_r == OP_PICK) && (rank_r >= total_w);
  assign set_new  = cmd.upd && (op_r == OP_SET) && !cur_bit;

  // Word scan: running count plus this word's bits passes the rank
  assign pc_w     = popcnt_word(rd_data_r);
  assign sum_w    = {1'b0, seen_r} + (CNT_W+1)'(pc_w);
  assign scan_hit = dv_r && ({1'b0, rank_r} < sum_w);

  // Byte and bit steps inside the hit word
  assign pc8_w    = popcnt_byte(sh_r[7:0]);
  assign byte_hit = ({2'b00, pc8_w} > (BIT_W)'(rem_r));
  assign bit_hit  = sh_r[0] && (rem_r == '0);

  // Memory port selection
  assign mem_we    = cmd.clr_wr || set_new;
  assign mem_waddr = cmd.clr_wr ? ptr_r : word_w;
  assign mem_wdata = cmd.clr_wr ? '0 : (rd_data_r | (WORD_W'(1) << bit_w));
  assign mem_raddr = cmd.scan ? ptr_r : word_w;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= op_t'(in_tuser);
      idx_r  <= reduce_index(in_tdata[15:0]);
      rank_r <= in_tdata[28:16];
    end
  end

  // Pattern flag and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (cmd.clr_wr && (ptr_r == LAST_WORD)) begin
        loaded_r <= 1'b1;
      end
      if (set_new) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  // Query bit
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      qbit_r <= cur_bit;
    end
  end

  // Word pointer shared by the clearing sweep and the rank scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      dv_r  <= 1'b0;
    end else if (cmd.capture) begin
      ptr_r <= '0;
      dv_r  <= 1'b0;
    end else if (cmd.clr_wr || cmd.scan) begin
      if (ptr_r != LAST_WORD) begin
        ptr_r <= ptr_r + WADDR_W'(1);
      end
      dv_r <= cmd.scan;
    end
  end

  // Rank select: word scan, then byte steps, then bit steps
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      seen_r <= '0;
    end else if (cmd.scan) begin
      wsel_r <= ptr_r;
      if (scan_hit) begin
        sh_r  <= rd_data_r;
        rem_r <= BIT_W'(rank_r - seen_r);
        pos_r <= {wsel_r, BIT_W'(0)};
      end else if (dv_r) begin
        seen_r <= sum_w[CNT_W-1:0];
      end
    end else if (cmd.byte_step && !byte_hit) begin
      rem_r <= rem_r - BIT_W'(pc8_w);
      sh_r  <= sh_r >> 8;
      pos_r <= pos_r + IDX_W'(8);
    end else if (cmd.bit_step && !bit_hit) begin
      if (sh_r[0]) begin
        rem_r <= rem_r - BIT_W'(1);
      end
      sh_r  <= sh_r >> 1;
      pos_r <= pos_r + IDX_W'(1);
    end
  end

  // Result register, reloaded only once the previous result is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      filled_r <= (op_r == OP_QUERY) && (loaded_r ? qbit_r : !idx_r[0]);
      total_r  <= total_w;
      err_r    <= rank_err;
      if ((op_r == OP_PICK) && !rank_err) begin
        picked_r <= loaded_r ? pos_r : {rank_r[IDX_W-2:0], 1'b0};
      end else begin
        picked_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, picked_r, total_r, filled_r};
  assign out_tuser  = err_r;

  // Status to the controller
  always_comb begin
    sts          = '0;
    sts.op       = op_r;
    sts.loaded   = loaded_r;
    sts.rank_err = rank_err;
    sts.clr_last = (ptr_r == LAST_WORD);
    sts.scan_hit = scan_hit;
    sts.byte_hit = byte_hit;
    sts.bit_hit  = bit_hit;
    sts.out_busy = out_valid_r && !out_tready;
  end

  // Checks
  `BFM_ASSERT(a_count_range, loaded_r, count_r <= CNT_MAX, "fill count above bucket count")
  `BFM_ASSERT_NEXT(a_loaded_sticky, loaded_r, loaded_r, "pattern flag dropped")
  `BFM_ASSERT(a_select_nonempty, cmd.byte_step || cmd.bit_step, sh_r != '0, "select past last filled bucket")
  `BFM_ASSERT_NEXT(a_count_step, cmd.upd && (op_r == OP_SET), (count_r == $past(count_r)) || (count_r == $past(count_r) + CNT_W'(1)), "fill count jumped")

endmodule

### rtl/core/bucket_fill_map_rank_select.sv
// Top level of the bucket fill map with rank select.
//
// Keeps a one-bit fill map of 5120 ring buckets. Until the first set request
// every even bucket counts as filled; the first set clears the map, then marks.
// Input channel in_*: in_tuser carries the op (set, query, count, pick);
// in_tdata carries bucket_index (reduced mod 5120) and rank.
// Output channel out_*: one result per request; out_tdata holds is_filled,
// filled_total and picked_bucket, out_tuser holds rank_error.
// A count, a failed pick or another default-mode request goes from dispatch straight
// to the result; set and query in the loaded map read the word, then set or sample
// its bit; the first set first clears all 80 map words in a sweep. A pick in the
// loaded map scans one 64-bit word per cycle, then takes up to 8 byte and 8 bit steps;
// the map memory's read port sets the word scan. One request is in work at a time.
// Reset (rst_n low, synchronous) returns to the default even pattern and empties
// the result register. A result waits in its register while out_tready is low;
// the next request is still taken and worked on, and holds only at its end.
module bucket_fill_map_rank_select (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // bucket_index[15:0], rank[28:16], zero fill
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // is_filled[0], filled_total[13:1], picked_bucket[26:14]
  output logic [0:0]  out_tuser   // rank_error[0]
);
  import bfmrs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bfmrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bfmrs_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
